@@ sv/brb_pkg.sv @@
// Shared constants, types and codes for the byte ring buffer with match.
`default_nettype none
package brb_pkg;

	localparam int RING_SIZE   = 256;
	localparam int PTR_W       = $clog2(RING_SIZE);
	localparam int MAX_PATTERN = 8;
	localparam int MAX_BURST   = 64;
	localparam int CNT_W       = $clog2(MAX_BURST + 1);
	localparam int LEN_W       = (PTR_W > 8) ? PTR_W : 8;
	localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_READ    = 3'd1,
		OP_POP     = 3'd2,
		OP_PEEK    = 3'd3,
		OP_CONSUME = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_PREFIX  = 3'd6,
		OP_SUFFIX  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		MC_NONE    = 2'd0,
		MC_PARTIAL = 2'd1,
		MC_FULL    = 2'd2
	} match_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_CMP_ADDR,
		ST_CMP_DATA,
		ST_CMP_RES
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  data_in;
		logic [7:0]  count;
		logic [63:0] pattern;
		logic [3:0]  pattern_len;
	} item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       data_valid;
		logic       last;
		logic [7:0] amount;
		logic       overwrote;
		logic [1:0] match_code;
		logic       suffix_match;
	} result_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [7:0]  count;
		logic [63:0] pattern;
		logic [3:0]  plen;
	} req_t;

endpackage
`default_nettype wire

@@ sv/brb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ sv/brb_front.sv @@
// Front end: accepts requests, saturates pattern length, queues them for the back end.
`default_nettype none
module brb_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire brb_pkg::item_t item,
	output logic                req_valid,
	output brb_pkg::req_t       req,
	input  wire logic           req_take
);
	import brb_pkg::*;

	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	req_t       cls;

	always_comb begin
		cls.op      = op_t'(item.opcode);
		cls.data    = item.data_in;
		cls.count   = item.count;
		cls.pattern = item.pattern;
		cls.plen    = (item.pattern_len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
		                                                   : item.pattern_len;
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(req_take);
		end
	end

endmodule
`default_nettype wire

@@ sv/brb_outq.sv @@
// Two-entry result queue between the back end and the result ports.
`default_nettype none
module brb_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire brb_pkg::result_t wr_data,
	output logic                  wr_full,
	output logic                  empty,
	input  wire logic             pop,
	output brb_pkg::result_t      result
);
	import brb_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign wr_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd      = pop && !empty;
	assign result  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd);
		end
	end

endmodule
`default_nettype wire

@@ sv/brb_back.sv @@
// Back end: pointer state, byte store sequencing, reads and pattern compares.
`default_nettype none
module brb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire brb_pkg::req_t  req,
	output logic                req_take,
	input  wire logic           out_full,
	output logic                out_wr,
	output brb_pkg::result_t    out_data
);
	import brb_pkg::*;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  wp_q, wp_d;
	logic [PTR_W-1:0]  rp_q, rp_d;
	logic [PTR_W-1:0]  base_q, base_d;
	logic [CNT_W-1:0]  n_q, n_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  idx_inc;
	logic [7:0]        amount_q, amount_d;
	logic [63:0]       pat_q, pat_d;
	logic              pfx_q, pfx_d;
	logic              partial_q, partial_d;
	logic              match_q, match_d;

	logic              ram_wr;
	logic              ram_rd;
	logic [PTR_W-1:0]  ram_rd_addr;
	logic [7:0]        ram_rd_data;

	logic [PTR_W-1:0]  used;
	logic [LEN_W-1:0]  used_x;
	logic [LEN_W-1:0]  cnt_x;
	logic [LEN_W-1:0]  plen_x;
	logic [LEN_W-1:0]  take_n;
	logic [LEN_W-1:0]  burst_n;
	logic [LEN_W-1:0]  cmp_n;
	logic              is_full;
	logic [7:0]        pat_byte;

	assign used    = wp_q - rp_q;
	assign used_x  = LEN_W'(used);
	assign cnt_x   = LEN_W'(req.count);
	assign plen_x  = LEN_W'(req.plen);
	assign take_n  = (cnt_x < used_x) ? cnt_x : used_x;
	assign burst_n = (take_n > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : take_n;
	assign cmp_n   = (plen_x < used_x) ? plen_x : used_x;
	assign is_full = (used == {PTR_W{1'b1}});
	assign idx_inc = idx_q + CNT_W'(1);
	assign pat_byte = pat_q[8 * idx_q[PIDX_W-1:0] +: 8];
	assign ram_rd_addr = base_q + PTR_W'(idx_q);

	brb_ram #(
		.WIDTH (8),
		.DEPTH (RING_SIZE)
	) u_store (
		.clk       (clk),
		.wr_en     (ram_wr),
		.wr_addr   (wp_q),
		.wr_data   (req.data),
		.rd_en     (ram_rd),
		.rd_addr   (ram_rd_addr),
		.rd_data_q (ram_rd_data)
	);

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		base_d    = base_q;
		n_d       = n_q;
		idx_d     = idx_q;
		amount_d  = amount_q;
		pat_d     = pat_q;
		pfx_d     = pfx_q;
		partial_d = partial_q;
		match_d   = match_q;
		req_take  = 1'b0;
		ram_wr    = 1'b0;
		ram_rd    = 1'b0;
		out_wr    = 1'b0;
		out_data  = '0;
		out_data.last = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (req_valid && !out_full) begin
					req_take  = 1'b1;
					idx_d     = '0;
					base_d    = rp_q;
					pat_d     = req.pattern;
					match_d   = 1'b1;
					case (req.op)
						OP_PUSH: begin
							ram_wr = 1'b1;
							wp_d   = wp_q + PTR_W'(1);
							if (is_full) begin
								rp_d = wp_q + PTR_W'(2);
							end
							out_wr             = 1'b1;
							out_data.amount    = 8'd1;
							out_data.overwrote = is_full;
						end
						OP_READ: begin
							if (burst_n == '0) begin
								out_wr = 1'b1;
							end else begin
								n_d      = CNT_W'(burst_n);
								amount_d = 8'(burst_n);
								rp_d     = rp_q + PTR_W'(burst_n);
								state_d  = ST_RD_ADDR;
							end
						end
						OP_POP, OP_PEEK: begin
							if (used == '0) begin
								out_wr = 1'b1;
							end else begin
								n_d      = CNT_W'(1);
								amount_d = 8'd1;
								if (req.op == OP_POP) begin
									rp_d = rp_q + PTR_W'(1);
								end
								state_d = ST_RD_ADDR;
							end
						end
						OP_CONSUME: begin
							rp_d            = rp_q + PTR_W'(take_n);
							out_wr          = 1'b1;
							out_data.amount = 8'(take_n);
						end
						OP_CLEAR: begin
							wp_d   = '0;
							rp_d   = '0;
							out_wr = 1'b1;
						end
						OP_PREFIX: begin
							if (used == '0 || req.plen == 4'd0) begin
								out_wr = 1'b1;
							end else begin
								n_d       = CNT_W'(cmp_n);
								pfx_d     = 1'b1;
								partial_d = (plen_x != cmp_n);
								state_d   = ST_CMP_ADDR;
							end
						end
						OP_SUFFIX: begin
							if (req.plen == 4'd0 || used_x < plen_x) begin
								out_wr = 1'b1;
							end else begin
								n_d     = CNT_W'(req.plen);
								base_d  = wp_q - PTR_W'(req.plen);
								pfx_d   = 1'b0;
								state_d = ST_CMP_ADDR;
							end
						end
						default: begin
							out_wr = 1'b1;
						end
					endcase
				end
			end
			ST_RD_ADDR: begin
				ram_rd  = 1'b1;
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (!out_full) begin
					out_wr              = 1'b1;
					out_data.data_out   = ram_rd_data;
					out_data.data_valid = 1'b1;
					out_data.amount     = amount_q;
					out_data.last       = (idx_inc == n_q);
					idx_d               = idx_inc;
					state_d             = (idx_inc == n_q) ? ST_IDLE : ST_RD_ADDR;
				end
			end
			ST_CMP_ADDR: begin
				ram_rd  = 1'b1;
				state_d = ST_CMP_DATA;
			end
			ST_CMP_DATA: begin
				if (ram_rd_data != pat_byte) begin
					match_d = 1'b0;
				end
				idx_d   = idx_inc;
				state_d = (idx_inc == n_q) ? ST_CMP_RES : ST_CMP_ADDR;
			end
			ST_CMP_RES: begin
				if (!out_full) begin
					out_wr = 1'b1;
					if (pfx_q) begin
						if (!match_q) begin
							out_data.match_code = MC_NONE;
						end else if (partial_q) begin
							out_data.match_code = MC_PARTIAL;
						end else begin
							out_data.match_code = MC_FULL;
						end
					end else begin
						out_data.suffix_match = match_q;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q    <= base_d;
		n_q       <= n_d;
		idx_q     <= idx_d;
		amount_q  <= amount_d;
		pat_q     <= pat_d;
		pfx_q     <= pfx_d;
		partial_q <= partial_d;
		match_q   <= match_d;
	end

endmodule
`default_nettype wire

@@ sv/byte_ring_buffer_with_match.sv @@
// Top level of the byte ring buffer with prefix and suffix match.
//
// Requests enter a two-entry queue and results leave through a two-entry
// queue; the back end between them works on one request at a time. Push,
// consume, clear, and any request that finds nothing to read or compare
// finish in the idle state. A read, pop or peek that delivers bytes passes
// an address and a data state per byte; a compare passes an address and a
// data state per byte, then a result state. The byte store is a single RAM
// with one registered read port, read once per byte. A full result queue
// holds the back end in idle, read-data and result states. Store contents
// need no clearing after reset; only bytes from tail to head are ever read.
`default_nettype none
module byte_ring_buffer_with_match (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire brb_pkg::item_t item,
	output logic                empty,
	input  wire logic           pop,
	output brb_pkg::result_t    result
);
	import brb_pkg::*;

	logic    req_valid;
	req_t    req;
	logic    req_take;
	logic    out_full;
	logic    out_wr;
	result_t out_data;

	brb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take)
	);

	brb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.out_data  (out_data)
	);

	brb_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_data),
		.wr_full (out_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire
